### src/assert_macros.svh
// Assertion macros shared by the reformatter RTL.
// No dependencies; take in with a bare include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define JTR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define JTR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### src/jtr_pkg.sv
// Package for the JSON text reformatter: sizes, byte codes and sequencer phases.
// No dependencies; imported by json_text_reformatter_core and its testbench.
`default_nettype none

package jtr_pkg;

   localparam int MAX_DEPTH    = 7;
   localparam int INDENT_WIDTH = 4;
   localparam int BYTE_W       = 8;
   localparam int DEPTH_W      = $clog2(MAX_DEPTH + 1);
   localparam int CNT_W        = $clog2(MAX_DEPTH * INDENT_WIDTH + 1);

   localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_NL1,
      PH_SP1,
      PH_MAIN,
      PH_NL2,
      PH_SP2,
      PH_COLON,
      PH_MARK
   } phase_type;

endpackage

`default_nettype wire

### src/json_text_reformatter_core.sv
// JSON minifier / pretty-printer: one source byte in, a run of output bytes out.
// At accept the sequencer plans the run; each result is then registered in the
// output register once that is free. A run of N results (N = 1 to 59) is stepped
// by the single-step space counter before the next byte is taken; dropped whitespace
// yields no result. Reset (synchronous, active high) clears stream state, sequencer
// and pretty_mode. Depends on jtr_pkg and assert_macros.svh.
`default_nettype none

module json_text_reformatter_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // source byte channel
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [jtr_pkg::BYTE_W-1:0] req_in_byte,
   input  wire logic                      req_end_of_input,
   // formatted byte channel
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [jtr_pkg::BYTE_W-1:0] rsp_out_byte,
   output      logic                      rsp_has_byte,
   output      logic                      rsp_last_of_run,
   output      logic                      rsp_end_of_output,
   // configuration
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_pretty_mode
);

   import jtr_pkg::*;

   // Stream state: lives across transactions, cleared at end of stream; pretty_ff only by reset
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               in_str_ff, in_str_in;
   logic               esc_ff, esc_in;
   logic               prev_open_ff, prev_open_in;
   logic               nl_pend_ff, nl_pend_in;
   logic               pretty_ff;

   // Per-transaction plan, latched at accept; the space count loads at each newline
   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               nl2_ff, nl2_in;
   logic               colon_ff, colon_in;
   logic [DEPTH_W-1:0] ind_ff, ind_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_has_ff, rsp_has_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_eoo_ff, rsp_eoo_in;

   // Decode of the incoming byte
   logic               accept;
   logic               emit_go;
   logic               is_ws, is_open, is_close;
   logic               has_nl1, has_main;
   phase_type          succ;
   logic [CNT_W-1:0]   indent_cnt;

   assign req_ready         = (phase_ff == PH_IDLE);
   assign accept            = req_valid & req_ready;
   // Advance the sequencer only when the output register is free or draining
   assign emit_go           = (phase_ff != PH_IDLE) & (~rsp_valid_ff | rsp_ready);
   assign indent_cnt        = CNT_W'(ind_ff * INDENT_WIDTH);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_has_byte      = rsp_has_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_end_of_output = rsp_eoo_ff;

   // Configuration register: the user must write it only while the block is quiet; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         pretty_ff <= 1'b0;
      end else if (csr_wr_en) begin
         pretty_ff <= csr_pretty_mode;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         depth_ff     <= '0;
         in_str_ff    <= 1'b0;
         esc_ff       <= 1'b0;
         prev_open_ff <= 1'b0;
         nl_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         depth_ff     <= depth_in;
         in_str_ff    <= in_str_in;
         esc_ff       <= esc_in;
         prev_open_ff <= prev_open_in;
         nl_pend_ff   <= nl_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      nl2_ff      <= nl2_in;
      colon_ff    <= colon_in;
      ind_ff      <= ind_in;
      cnt_ff      <= cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eoo_ff  <= rsp_eoo_in;
   end

   // Sequencer: plan the run at accept, then step one result per free cycle
   always_comb begin
      is_ws    = req_in_byte inside {CH_SPACE, CH_CR, CH_LF, CH_TAB};
      is_open  = req_in_byte inside {CH_LBRACE, CH_LBRACKET};
      is_close = req_in_byte inside {CH_RBRACE, CH_RBRACKET};

      phase_in     = phase_ff;
      depth_in     = depth_ff;
      in_str_in    = in_str_ff;
      esc_in       = esc_ff;
      prev_open_in = prev_open_ff;
      nl_pend_in   = nl_pend_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      nl2_in       = nl2_ff;
      colon_in     = colon_ff;
      ind_in       = ind_ff;
      cnt_in       = cnt_ff;
      has_nl1      = 1'b0;
      has_main     = 1'b0;
      succ         = PH_IDLE;

      // Drain the output register when the consumer takes it
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eoo_in   = rsp_eoo_ff;

      if (accept) begin
         byte_in  = req_in_byte;
         last_in  = req_end_of_input;
         nl2_in   = 1'b0;
         colon_in = 1'b0;

         if (in_str_ff) begin
            // String body: pass through, track escapes and the closing quote
            has_main = 1'b1;
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (req_in_byte == CH_BACKSLASH) begin
               esc_in = 1'b1;
            end else if (req_in_byte == CH_QUOTE) begin
               in_str_in = 1'b0;
            end
         end else if (!is_ws) begin
            has_main   = 1'b1;
            nl_pend_in = 1'b0;
            // Resolve the held-back newline unless the container is empty
            if (nl_pend_ff && !is_close) begin
               has_nl1 = 1'b1;
            end
            if (req_in_byte == CH_QUOTE) begin
               in_str_in = 1'b1;
            end
            if (is_open) begin
               if (depth_ff < DEPTH_W'(MAX_DEPTH)) begin
                  depth_in = depth_ff + 1'b1;
               end
               if (pretty_ff) begin
                  nl_pend_in = 1'b1;
               end
            end
            if (is_close) begin
               if (depth_ff != '0) begin
                  depth_in = depth_ff - 1'b1;
               end
               if (pretty_ff && !prev_open_ff) begin
                  has_nl1 = 1'b1;
               end
            end
            nl2_in       = pretty_ff & (req_in_byte == CH_COMMA);
            colon_in     = pretty_ff & (req_in_byte == CH_COLON);
            prev_open_in = is_open;
         end

         // A closing bracket indents at the new depth, all else at the old one
         ind_in = (!in_str_ff && is_close) ? depth_in : depth_ff;

         // End of stream: drop everything including a dangling newline
         if (req_end_of_input) begin
            depth_in     = '0;
            in_str_in    = 1'b0;
            esc_in       = 1'b0;
            prev_open_in = 1'b0;
            nl_pend_in   = 1'b0;
         end

         if (has_nl1) begin
            phase_in = PH_NL1;
         end else if (has_main) begin
            phase_in = PH_MAIN;
         end else if (req_end_of_input) begin
            phase_in = PH_MARK;
         end else begin
            phase_in = PH_IDLE;
         end
      end else if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_has_in   = 1'b1;
         rsp_byte_in  = CH_SPACE;

         case (phase_ff)
            PH_NL1: begin
               rsp_byte_in = CH_LF;
               cnt_in      = indent_cnt;
               succ        = (ind_ff != '0) ? PH_SP1 : PH_MAIN;
            end
            PH_SP1: begin
               cnt_in = cnt_ff - 1'b1;
               succ   = (cnt_ff == CNT_W'(1)) ? PH_MAIN : PH_SP1;
            end
            PH_MAIN: begin
               rsp_byte_in = byte_ff;
               if (nl2_ff) begin
                  succ = PH_NL2;
               end else if (colon_ff) begin
                  succ = PH_COLON;
               end else begin
                  succ = PH_IDLE;
               end
            end
            PH_NL2: begin
               rsp_byte_in = CH_LF;
               cnt_in      = indent_cnt;
               succ        = (ind_ff != '0) ? PH_SP2 : PH_IDLE;
            end
            PH_SP2: begin
               cnt_in = cnt_ff - 1'b1;
               succ   = (cnt_ff == CNT_W'(1)) ? PH_IDLE : PH_SP2;
            end
            PH_COLON: begin
               succ = PH_IDLE;
            end
            PH_MARK: begin
               rsp_byte_in = CH_NUL;
               rsp_has_in  = 1'b0;
               succ        = PH_IDLE;
            end
            default: begin
               succ = PH_IDLE;
            end
         endcase

         phase_in    = succ;
         rsp_last_in = (succ == PH_IDLE);
         rsp_eoo_in  = last_ff & (succ == PH_IDLE);
      end
   end

   `include "assert_macros.svh"

   // End of stream must leave every piece of stream state at its reset value
   `JTR_ASSERT(a_eos_clears, (accept && req_end_of_input) |=> (depth_ff == '0 && !in_str_ff && !esc_ff && !nl_pend_ff && !prev_open_ff), "stream state not cleared at end of stream")
   // The last transaction of a stream also closes its run
   `JTR_ASSERT(a_eoo_last, (rsp_valid && rsp_end_of_output) |-> rsp_last_of_run, "end of output without last of run")
   // A bare marker appears only to close the stream
   `JTR_ASSERT(a_marker_eoo, (rsp_valid && !rsp_has_byte) |-> rsp_end_of_output, "bare marker outside end of stream")
   // Nesting depth saturates and never wraps
   `JTR_ASSERT(a_depth_sat, depth_ff <= DEPTH_W'(MAX_DEPTH), "nesting depth beyond saturation")

endmodule

`default_nettype wire

### bench/tb_json_text_reformatter_core.sv
`timescale 1ns / 100ps
// Testbench for json_text_reformatter_core: a directed table followed by random JSON-like
// streams; each output byte is checked against the byte-level formatter model kept here
// or the hand-typed result of a row. Depends on jtr_pkg and the RTL under src/.

module tb_json_text_reformatter_core;
   import jtr_pkg::*;

   // One output transaction of the formatted byte channel.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              last_of_run;
      logic              end_of_output;
   } fmt_result_type;

   // One source byte transaction.
   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              eoi;
   } src_byte_type;

   // Directed row: mode to run in, byte to send, and an optional hand-typed result.
   typedef struct packed {
      logic           pretty;
      src_byte_type   src;
      logic           fixed;
      fmt_result_type want;
   } dir_row_type;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   localparam int N_DIR        = 25;
   localparam int N_PHASES     = 7;
   localparam int PHASE_ITEMS  = 41;
   localparam int LONG_HOLD    = 160;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES  = 40;

   localparam fmt_result_type NO_WANT = '0;

   // Directed rows. The first four start a fresh stream each and end it at once, so
   // their single result can be written down directly; so can the lone bracket at the end,
   // whose pending newline is dropped by end of stream.
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{1'b0, '{"a",          1'b1}, 1'b1, '{"a",         1'b1, 1'b1, 1'b1}},
      '{1'b0, '{8'h00,        1'b1}, 1'b1, '{8'h00,       1'b1, 1'b1, 1'b1}},
      '{1'b0, '{8'hFF,        1'b1}, 1'b1, '{8'hFF,       1'b1, 1'b1, 1'b1}},
      '{1'b0, '{CH_SPACE,     1'b1}, 1'b1, '{CH_NUL,      1'b0, 1'b1, 1'b1}},
      '{1'b0, '{CH_TAB,       1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_LBRACE,    1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_QUOTE,     1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_BACKSLASH, 1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_QUOTE,     1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_SPACE,     1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_QUOTE,     1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_COLON,     1'b0}, 1'b0, NO_WANT},
      '{1'b0, '{CH_RBRACE,    1'b1}, 1'b0, NO_WANT},
      '{1'b1, '{CH_LBRACE,    1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_LBRACKET,  1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_RBRACKET,  1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_COMMA,     1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_COLON,     1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_LBRACKET,  1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_LF,        1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{"7",          1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_RBRACKET,  1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_RBRACE,    1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_RBRACKET,  1'b0}, 1'b0, NO_WANT},
      '{1'b1, '{CH_LBRACKET,  1'b1}, 1'b1, '{CH_LBRACKET, 1'b1, 1'b1, 1'b1}}
   };

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic [BYTE_W-1:0] req_in_byte      = '0;
   logic              req_end_of_input = 1'b0;
   logic              rsp_ready        = 1'b0;
   logic              csr_wr_en        = 1'b0;
   logic              csr_pretty_mode  = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_has_byte;
   logic              rsp_last_of_run;
   logic              rsp_end_of_output;

   // Formatter model state, kept in step with every accepted source byte.
   logic               pretty_q;
   logic [DEPTH_W-1:0] depth_q;
   logic               in_string_q;
   logic               escape_q;
   logic               after_open_q;
   logic               nl_pending_q;

   fmt_result_type run_q[$];           // results of the byte being modelled
   fmt_result_type expected_out_q[$];  // formatted bytes still to come, oldest first
   src_byte_type   src_q[$];           // random source bytes not yet offered

   int mismatches   = 0;
   int burst_left   = 0;
   bit hold_request = 1'b0;

   json_text_reformatter_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_output (rsp_end_of_output),
      .csr_wr_en         (csr_wr_en),
      .csr_pretty_mode   (csr_pretty_mode)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- formatter model

   function automatic void clear_stream_state();
      depth_q      = '0;
      in_string_q  = 1'b0;
      escape_q     = 1'b0;
      after_open_q = 1'b0;
      nl_pending_q = 1'b0;
   endfunction

   function automatic void put_byte(input logic [BYTE_W-1:0] b);
      fmt_result_type r;
      r.out_byte      = b;
      r.has_byte      = 1'b1;
      r.last_of_run   = 1'b0;
      r.end_of_output = 1'b0;
      run_q.push_back(r);
   endfunction

   // Newline plus the indent of the current (already saturated) depth.
   function automatic void put_newline();
      put_byte(CH_LF);
      repeat (int'(depth_q) * INDENT_WIDTH) put_byte(CH_SPACE);
   endfunction

   // Work out every output byte that one source byte causes, into run_q.
   function automatic void reformat_byte(input logic [BYTE_W-1:0] c, input logic eoi);
      fmt_result_type tail;
      run_q.delete();
      if (in_string_q) begin
         // strings pass through untouched; an escaped byte never ends them
         put_byte(c);
         if (escape_q) escape_q = 1'b0;
         else if (c == CH_BACKSLASH) escape_q = 1'b1;
         else if (c == CH_QUOTE) in_string_q = 1'b0;
      end else if (c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB) begin
         // drop blanks between tokens
      end else begin
         // a pending newline after an opener is settled by the first real token,
         // and swallowed if that token closes the container straight away
         if (nl_pending_q) begin
            nl_pending_q = 1'b0;
            if (c != CH_RBRACE && c != CH_RBRACKET) put_newline();
         end
         if (c == CH_QUOTE) begin
            in_string_q = 1'b1;
            put_byte(c);
         end else if (c == CH_LBRACE || c == CH_LBRACKET) begin
            put_byte(c);
            if (depth_q < MAX_DEPTH) depth_q++;
            if (pretty_q) nl_pending_q = 1'b1;
         end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
            if (depth_q > 0) depth_q--;
            if (pretty_q && !after_open_q) put_newline();
            put_byte(c);
         end else if (c == CH_COMMA) begin
            put_byte(c);
            if (pretty_q) put_newline();
         end else if (c == CH_COLON) begin
            put_byte(c);
            if (pretty_q) put_byte(CH_SPACE);
         end else begin
            put_byte(c);
         end
         after_open_q = (c == CH_LBRACE || c == CH_LBRACKET);
      end

      if (eoi) begin
         // a final byte with nothing to show still yields a bare end marker
         if (run_q.size() == 0) begin
            tail = '0;
            run_q.push_back(tail);
         end
         tail = run_q.pop_back();
         tail.end_of_output = 1'b1;
         run_q.push_back(tail);
         clear_stream_state();
      end
      if (run_q.size() > 0) begin
         tail = run_q.pop_back();
         tail.last_of_run = 1'b1;
         run_q.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------- random streams

   function automatic logic [BYTE_W-1:0] pick_blank();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_CR;
         2:       return CH_LF;
         default: return CH_TAB;
      endcase
   endfunction

   function automatic void push_src(input logic [BYTE_W-1:0] c);
      src_byte_type s;
      s.in_byte = c;
      s.eoi     = 1'b0;
      src_q.push_back(s);
   endfunction

   // Queue one stream: mostly token soup built from JSON punctuation, strings with
   // escapes and scalars, sometimes deeply nested, now and then pure noise bytes.
   function automatic void queue_stream();
      int                len;
      int                r;
      int                open_w;
      logic [BYTE_W-1:0] c;
      src_byte_type      tail;
      len    = $urandom_range(4, 40);
      open_w = ($urandom_range(0, 3) == 0) ? 45 : 22;
      if ($urandom_range(0, 9) == 0) begin
         repeat (len) push_src(BYTE_W'($urandom_range(0, 255)));
      end else begin
         while (src_q.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < open_w) begin
               push_src($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
            end else if (r < open_w + 18) begin
               push_src($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
            end else if (r < open_w + 28) begin
               push_src(CH_COMMA);
            end else if (r < open_w + 35) begin
               push_src(CH_COLON);
            end else if (r < open_w + 47) begin
               push_src(CH_QUOTE);
               repeat ($urandom_range(0, 5)) begin
                  c = BYTE_W'($urandom_range(0, 255));
                  if ($urandom_range(0, 4) == 0) push_src(CH_BACKSLASH);
                  else if (c == CH_QUOTE || c == CH_BACKSLASH) c = "x";
                  push_src(c);
               end
               push_src(CH_QUOTE);
            end else if (r < open_w + 55) begin
               push_src(pick_blank());
            end else if (r < 97) begin
               // digits or lower-case letters
               push_src($urandom_range(0, 1) ? BYTE_W'($urandom_range(8'h30, 8'h39))
                                             : BYTE_W'($urandom_range(8'h61, 8'h7A)));
            end else begin
               push_src(BYTE_W'($urandom_range(0, 255)));
            end
         end
         // leave a string open at the end now and then, or end on a blank
         if ($urandom_range(0, 9) == 0) push_src(CH_QUOTE);
         if ($urandom_range(0, 5) == 0) push_src(pick_blank());
      end
      tail = src_q.pop_back();
      tail.eoi = 1'b1;
      src_q.push_back(tail);
   endfunction

   // ---------------------------------------------------------------- source side

   // Offer one byte, hold it until accepted, then log what it should produce.
   // Bursts of random length are separated by random gaps.
   task automatic offer(input src_byte_type s, input logic fixed, input fmt_result_type want);
      req_valid        <= 1'b1;
      req_in_byte      <= s.in_byte;
      req_end_of_input <= s.eoi;
      do @(posedge clock); while (!req_ready);
      reformat_byte(s.in_byte, s.eoi);
      if (fixed) expected_out_q.push_back(want);
      else foreach (run_q[i]) expected_out_q.push_back(run_q[i]);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 30);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Change the format mode with the block idle: wait for every pending byte,
   // then DRAIN_CYCLES more for a dropped blank that may still be in flight.
   task automatic set_pretty(input logic mode);
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en       <= 1'b1;
      csr_pretty_mode <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pretty_q = mode;
   endtask

   initial begin : stimulus
      logic mode;
      pretty_q = 1'b0;
      clear_stream_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table; switch mode only where the row asks for it.
      for (int i = 0; i < N_DIR; i++) begin
         if (i == 0 || DIR_ROWS[i].pretty != pretty_q) set_pretty(DIR_ROWS[i].pretty);
         offer(DIR_ROWS[i].src, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
      end

      // Random phases. Each begins by draining and rewriting the mode, so streams
      // may change mode halfway. The first phase also starves the output for a
      // long stretch while bytes keep coming.
      for (int p = 0; p < N_PHASES; p++) begin
         if (p == 0) mode = 1'b1;
         else if (p == 1) mode = 1'b0;
         else mode = 1'($urandom_range(0, 1));
         set_pretty(mode);
         if (p == 0) hold_request = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (src_q.size() == 0) queue_stream();
            offer(src_q.pop_front(), 1'b0, NO_WANT);
         end
      end

      // Drain, then give the block time to show any stray output.
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // Back-pressure on a pattern of its own; a requested long hold is counted here.
   initial begin : rsp_side
      rx_mode_type rx_mode;
      int          beat;
      int          hold_cnt;
      beat = 0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge clock);
         end else begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            repeat ($urandom_range(8, 48)) begin
               case (rx_mode)
                  RX_ALWAYS: rsp_ready <= 1'b1;
                  RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                  RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default:   rsp_ready <= beat[2];
               endcase
               beat++;
               @(posedge clock);
            end
         end
      end
   end

   // Compare each accepted output transaction with the oldest expected byte.
   always @(posedge clock) begin : result_check
      fmt_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected output byte %02h has %b last %b end %b", $realtime,
                        rsp_out_byte, rsp_has_byte, rsp_last_of_run, rsp_end_of_output);
         end else begin
            want = expected_out_q.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_has_byte !== want.has_byte ||
                rsp_last_of_run !== want.last_of_run ||
                rsp_end_of_output !== want.end_of_output) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected byte %02h has %b last %b end %b, got %02h %b %b %b",
                           $realtime, want.out_byte, want.has_byte, want.last_of_run,
                           want.end_of_output, rsp_out_byte, rsp_has_byte, rsp_last_of_run,
                           rsp_end_of_output);
            end
         end
      end
   end

endmodule

### files.f
+incdir+src
src/jtr_pkg.sv
src/json_text_reformatter_core.sv
bench/tb_json_text_reformatter_core.sv
